### hdl/vrp_pkg.sv
// Package for the video register port: codes, widths and shared constants.
package vrp_pkg;

  localparam int NT_DEPTH_DEF  = 4096;
  localparam int SPR_DEPTH     = 256;
  localparam int PAL_DEPTH     = 32;
  localparam int SPR_AW        = 8;
  localparam int PAL_AW        = 5;
  localparam int PAL_W         = 6;
  localparam int VADDR_W       = 14;

  localparam logic [5:0] PAL_PAGE     = 6'h3F;
  localparam logic [6:0] STATUS_LOW   = 7'h20;
  localparam logic [7:0] VADDR_HI_MSK = 8'h3F;

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_WRITE  = 2'd1,
    OP_VBLANK = 2'd2
  } op_e;

  localparam logic [2:0] REG_CONTROL = 3'd0;
  localparam logic [2:0] REG_MASK    = 3'd1;
  localparam logic [2:0] REG_STATUS  = 3'd2;
  localparam logic [2:0] REG_SPR_ADR = 3'd3;
  localparam logic [2:0] REG_SPR_DAT = 3'd4;
  localparam logic [2:0] REG_SCROLL  = 3'd5;
  localparam logic [2:0] REG_VADDR   = 3'd6;
  localparam logic [2:0] REG_VDATA   = 3'd7;

  typedef struct packed {
    logic clear_step;
    logic latch;
    logic exec;
  } vrp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } vrp_stat_t;

endpackage

### hdl/vrp_ram.sv
// Generic simple dual-port RAM with registered read.
module vrp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/vrp_ctrl.sv
// Sequencer for the video register port: clear pass, accept, fetch, execute.
module vrp_ctrl
  import vrp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  vrp_stat_t stat_i,
  output vrp_cmd_t  cmd_o,
  output logic      busy_o
);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_FETCH = 4'b0100,
    S_EXEC  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (stat_i.clear_last) state_d = S_IDLE;
      S_IDLE:  if (start_i) state_d = S_FETCH;
      S_FETCH: state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o           = (state_q != S_IDLE);
  assign cmd_o.clear_step = (state_q == S_CLEAR);
  assign cmd_o.latch      = (state_q == S_IDLE) && start_i;
  assign cmd_o.exec       = (state_q == S_EXEC);

endmodule

### hdl/vrp_dpath.sv
// Datapath: register file, video address logic and the three stores.
module vrp_dpath
  import vrp_pkg::*;
#(
  parameter int NameTableDepth = NT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  vrp_cmd_t   cmd_i,
  output vrp_stat_t  stat_o,
  input  logic [1:0] op_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] data_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic [7:0] control_o,
  output logic [7:0] mask_bits_o,
  output logic [7:0] scroll_x_o,
  output logic [7:0] scroll_y_o,
  output logic       vblank_o
);

  localparam int     NtAw    = $clog2(NameTableDepth);
  // floor(a / depth) as (a * recip) >> shift, exact for 14-bit a
  localparam int     NtShift = VADDR_W + NtAw;
  localparam longint NtRecip = ((longint'(1) << NtShift) + NameTableDepth - 1)
                               / NameTableDepth;
  localparam int     RecipW  = $clog2(NtRecip + 1);
  localparam int     ProdW   = VADDR_W + RecipW;
  localparam int     QuotW   = ProdW - NtShift;

  // latched item
  logic [1:0] op_q;
  logic [2:0] reg_q;
  logic [7:0] data_q;

  // architectural state
  logic [7:0]         control_q, control_d;
  logic [7:0]         mask_q, mask_d;
  logic               vblank_q, vblank_d;
  logic [SPR_AW-1:0]  spr_addr_q, spr_addr_d;
  logic [7:0]         scroll_h_q, scroll_h_d;
  logic [7:0]         scroll_v_q, scroll_v_d;
  logic               toggle_q, toggle_d;
  logic [VADDR_W-1:0] vaddr_q, vaddr_d;
  logic [7:0]         rd_q, rd_d;
  logic               done_q;

  logic [NtAw-1:0]    clr_cnt_q;
  logic [ProdW-1:0]   prod_q;

  logic [QuotW-1:0]   nt_quot;
  logic [VADDR_W-1:0] nt_qd;
  logic [NtAw-1:0]    nt_slot;
  logic               is_pal;
  logic [VADDR_W-1:0] vstep;

  logic               is_wr;
  logic               spr_we, nt_we, pal_we;
  logic [SPR_AW-1:0]  spr_waddr;
  logic [NtAw-1:0]    nt_waddr;
  logic [PAL_AW-1:0]  pal_waddr;
  logic [7:0]         spr_wdata, nt_wdata;
  logic [PAL_W-1:0]   pal_wdata;
  logic [7:0]         spr_rdata, nt_rdata;
  logic [PAL_W-1:0]   pal_rdata;

  // name-table slot: vaddr mod depth; prod_q is registered from vaddr,
  // and vaddr never moves in the cycle before an item is accepted
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(vaddr_q) * ProdW'(NtRecip);
  end

  assign nt_quot = prod_q[ProdW-1:NtShift];
  assign nt_qd   = VADDR_W'(nt_quot * NameTableDepth);
  assign nt_slot = NtAw'(vaddr_q - nt_qd);
  assign is_pal  = (vaddr_q[VADDR_W-1:8] == PAL_PAGE);
  assign vstep   = control_q[2] ? VADDR_W'(32) : VADDR_W'(1);

  assign is_wr = cmd_i.exec && (op_q == OP_WRITE);

  // item latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_i;
      reg_q  <= reg_index_i;
      data_q <= data_i;
    end
  end

  always_comb begin
    control_d  = control_q;
    mask_d     = mask_q;
    vblank_d   = vblank_q;
    spr_addr_d = spr_addr_q;
    scroll_h_d = scroll_h_q;
    scroll_v_d = scroll_v_q;
    toggle_d   = toggle_q;
    vaddr_d    = vaddr_q;
    rd_d       = rd_q;
    if (cmd_i.exec) begin
      rd_d = '0;
      case (op_q)
        OP_READ: begin
          case (reg_q)
            REG_STATUS: begin
              rd_d     = {vblank_q, STATUS_LOW};
              vblank_d = 1'b0;
              toggle_d = 1'b0;
            end
            REG_SPR_DAT: rd_d = spr_rdata;
            REG_VDATA: begin
              rd_d    = is_pal ? {2'b00, pal_rdata} : nt_rdata;
              vaddr_d = vaddr_q + vstep;
            end
            default: ;
          endcase
        end
        OP_WRITE: begin
          case (reg_q)
            REG_CONTROL: control_d  = data_q;
            REG_MASK:    mask_d     = data_q;
            REG_SPR_ADR: spr_addr_d = data_q;
            REG_SPR_DAT: spr_addr_d = spr_addr_q + SPR_AW'(1);
            REG_SCROLL: begin
              if (!toggle_q) scroll_h_d = data_q;
              else           scroll_v_d = data_q;
              toggle_d = !toggle_q;
            end
            REG_VADDR: begin
              if (!toggle_q) vaddr_d = {data_q[5:0] & VADDR_HI_MSK[5:0], 8'h00};
              else           vaddr_d = {vaddr_q[VADDR_W-1:8], data_q};
              toggle_d = !toggle_q;
            end
            REG_VDATA: vaddr_d = vaddr_q + vstep;
            default: ;
          endcase
        end
        OP_VBLANK: vblank_d = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q  <= '0;
      mask_q     <= '0;
      vblank_q   <= 1'b1;
      spr_addr_q <= '0;
      scroll_h_q <= '0;
      scroll_v_q <= '0;
      toggle_q   <= 1'b0;
      vaddr_q    <= '0;
      rd_q       <= '0;
      done_q     <= 1'b0;
      clr_cnt_q  <= '0;
    end else begin
      control_q  <= control_d;
      mask_q     <= mask_d;
      vblank_q   <= vblank_d;
      spr_addr_q <= spr_addr_d;
      scroll_h_q <= scroll_h_d;
      scroll_v_q <= scroll_v_d;
      toggle_q   <= toggle_d;
      vaddr_q    <= vaddr_d;
      rd_q       <= rd_d;
      done_q     <= cmd_i.exec;
      if (cmd_i.clear_step) clr_cnt_q <= clr_cnt_q + NtAw'(1);
    end
  end

  assign stat_o.clear_last = (clr_cnt_q == NtAw'(NameTableDepth - 1));

  // store ports; the clear pass zeroes all three stores in parallel
  always_comb begin
    spr_we    = is_wr && (reg_q == REG_SPR_DAT);
    nt_we     = is_wr && (reg_q == REG_VDATA) && !is_pal;
    pal_we    = is_wr && (reg_q == REG_VDATA) && is_pal;
    spr_waddr = spr_addr_q;
    nt_waddr  = nt_slot;
    pal_waddr = vaddr_q[PAL_AW-1:0];
    spr_wdata = data_q;
    nt_wdata  = data_q;
    pal_wdata = data_q[PAL_W-1:0];
    if (cmd_i.clear_step) begin
      spr_we    = 1'b1;
      nt_we     = 1'b1;
      pal_we    = 1'b1;
      spr_waddr = clr_cnt_q[SPR_AW-1:0];
      nt_waddr  = clr_cnt_q;
      pal_waddr = clr_cnt_q[PAL_AW-1:0];
      spr_wdata = '0;
      nt_wdata  = '0;
      pal_wdata = '0;
    end
  end

  vrp_ram #(.Width(8), .Depth(SPR_DEPTH)) u_spr_ram (
    .clk_i   (clk_i),
    .we_i    (spr_we),
    .waddr_i (spr_waddr),
    .wdata_i (spr_wdata),
    .raddr_i (spr_addr_q),
    .rdata_o (spr_rdata)
  );

  vrp_ram #(.Width(8), .Depth(NameTableDepth)) u_nt_ram (
    .clk_i   (clk_i),
    .we_i    (nt_we),
    .waddr_i (nt_waddr),
    .wdata_i (nt_wdata),
    .raddr_i (nt_slot),
    .rdata_o (nt_rdata)
  );

  vrp_ram #(.Width(PAL_W), .Depth(PAL_DEPTH)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pal_waddr),
    .wdata_i (pal_wdata),
    .raddr_i (vaddr_q[PAL_AW-1:0]),
    .rdata_o (pal_rdata)
  );

  assign done_o      = done_q;
  assign read_data_o = rd_q;
  assign control_o   = control_q;
  assign mask_bits_o = mask_q;
  assign scroll_x_o  = scroll_h_q;
  assign scroll_y_o  = scroll_v_q;
  assign vblank_o    = vblank_q;

endmodule

### hdl/video_register_port_unit.sv
// Top level of the video register port: sequencer plus datapath.
//
// Usage:
// - Command channel: an item (op_i, reg_index_i, data_i) transfers at a
//   rising edge where start_i is high and busy_o is low. op_i selects a
//   register read, a register write or the start of vertical blank.
// - Result channel: done_o is high for exactly one cycle per item; in that
//   cycle read_data_o carries the byte read (zero otherwise) and
//   control_o, mask_bits_o, scroll_x_o, scroll_y_o and vblank_o show the
//   register state left by the item. The receiver cannot stall; results
//   are never held back.
// - Timing: the item passes the fetch and then the execute state; done_o
//   is registered from execute, and the result transfers as its pulse ends.
// - Item flow: the port takes no new item while one is in flight. The item
//   needs a fetch state for the registered read of the sprite, name-table
//   or palette RAM and an execute state for the update; the next transfer
//   can happen in the cycle done_o is high.
// - Reset: rst_ni is asynchronous, active low. After release a clearing
//   pass zeroes the three RAMs, one entry per cycle in parallel, up to
//   the last name-table entry; busy_o stays high until it ends. Status resets
//   to 0xA0, so vblank_o starts at one.
module video_register_port_unit
  import vrp_pkg::*;
#(
  parameter int NameTableDepth = NT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic [1:0] op_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] data_i,
  output logic       done_o,
  output logic [7:0] read_data_o,
  output logic [7:0] control_o,
  output logic [7:0] mask_bits_o,
  output logic [7:0] scroll_x_o,
  output logic [7:0] scroll_y_o,
  output logic       vblank_o
);

  vrp_cmd_t  cmd;
  vrp_stat_t stat;

  vrp_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  vrp_dpath #(.NameTableDepth(NameTableDepth)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .op_i        (op_i),
    .reg_index_i (reg_index_i),
    .data_i      (data_i),
    .done_o      (done_o),
    .read_data_o (read_data_o),
    .control_o   (control_o),
    .mask_bits_o (mask_bits_o),
    .scroll_x_o  (scroll_x_o),
    .scroll_y_o  (scroll_y_o),
    .vblank_o    (vblank_o)
  );

  // every transfer yields its result strobe
  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##3 done_o)
    else $error("result strobe missing after transfer");

  // the strobe is a single-cycle pulse
  a_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  // the port is ready again while a result is shown
  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("busy while result strobe is high");

  // a transfer always starts work
  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("transfer did not start work");

endmodule

### dv/vrp_port_checker.sv
// Checker for the video register port: tracks transfers, predicts results, compares fields.
module vrp_port_checker
  import vrp_pkg::*;
#(
  parameter int NameTableDepth = NT_DEPTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       busy_i,
  input  logic [1:0] op_i,
  input  logic [2:0] reg_index_i,
  input  logic [7:0] data_i,
  input  logic       done_i,
  input  logic [7:0] read_data_i,
  input  logic [7:0] control_i,
  input  logic [7:0] mask_bits_i,
  input  logic [7:0] scroll_x_i,
  input  logic [7:0] scroll_y_i,
  input  logic       vblank_i,
  output int         outstanding_o,
  output int         error_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [VADDR_W-1:0] PalBase    = {PAL_PAGE, 8'h00};
  localparam logic [7:0]         StatusInit = {1'b1, STATUS_LOW};
  localparam int                 IncBit     = 2;

  typedef struct packed {
    logic [7:0] read_data;
    logic [7:0] control;
    logic [7:0] mask_bits;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic       vblank;
  } port_result_t;

  // shadow of the register file and the three stores
  logic [7:0]         ctrl_q, mask_q, status_q, spr_addr_q, scroll_h_q, scroll_v_q;
  logic               toggle_q;
  logic [VADDR_W-1:0] vaddr_q;
  logic [7:0]         spr_mem [SPR_DEPTH];
  logic [7:0]         nt_mem  [NameTableDepth];
  logic [PAL_W-1:0]   pal_mem [PAL_DEPTH];

  port_result_t expected_q [$];
  int           fail_total = 0;

  // applies one register access to the shadow state, returns the port's result
  function automatic port_result_t apply_access(logic [1:0] op, logic [2:0] idx,
                                                logic [7:0] din);
    port_result_t       res;
    logic               on_palette;
    int                 nt_slot;
    logic [PAL_AW-1:0]  pal_slot;
    logic [VADDR_W-1:0] step;
    res        = '0;
    on_palette = (vaddr_q >= PalBase);
    nt_slot    = int'(vaddr_q) % NameTableDepth;
    pal_slot   = PAL_AW'(vaddr_q - PalBase);
    step       = ctrl_q[IncBit] ? VADDR_W'(32) : VADDR_W'(1);
    case (op)
      OP_READ: begin
        case (idx)
          REG_STATUS: begin
            res.read_data = status_q;
            status_q[7]   = 1'b0;
            toggle_q      = 1'b0;
          end
          REG_SPR_DAT: res.read_data = spr_mem[spr_addr_q];
          REG_VDATA: begin
            res.read_data = on_palette ? {2'b00, pal_mem[pal_slot]} : nt_mem[nt_slot];
            vaddr_q       = vaddr_q + step;
          end
          default: ;
        endcase
      end
      OP_WRITE: begin
        case (idx)
          REG_CONTROL: ctrl_q = din;
          REG_MASK:    mask_q = din;
          REG_SPR_ADR: spr_addr_q = din;
          REG_SPR_DAT: begin
            spr_mem[spr_addr_q] = din;
            spr_addr_q          = spr_addr_q + 8'd1;
          end
          REG_SCROLL: begin
            if (!toggle_q) scroll_h_q = din;
            else scroll_v_q = din;
            toggle_q = !toggle_q;
          end
          REG_VADDR: begin
            if (!toggle_q) vaddr_q = VADDR_W'(din & VADDR_HI_MSK) << 8;
            else vaddr_q = {vaddr_q[VADDR_W-1:8], din};
            toggle_q = !toggle_q;
          end
          REG_VDATA: begin
            if (on_palette) pal_mem[pal_slot] = din[PAL_W-1:0];
            else nt_mem[nt_slot] = din;
            vaddr_q = vaddr_q + step;
          end
          default: ;  // status is read only
        endcase
      end
      OP_VBLANK: status_q[7] = 1'b1;
      default: ;      // unused op code
    endcase
    res.control   = ctrl_q;
    res.mask_bits = mask_q;
    res.scroll_x  = scroll_h_q;
    res.scroll_y  = scroll_v_q;
    res.vblank    = status_q[7];
    return res;
  endfunction

  function automatic int check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%02h, got 0x%02h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    port_result_t want;
    if (!rst_ni) begin
      ctrl_q     = '0;
      mask_q     = '0;
      status_q   = StatusInit;
      spr_addr_q = '0;
      scroll_h_q = '0;
      scroll_v_q = '0;
      toggle_q   = 1'b0;
      vaddr_q    = '0;
      foreach (spr_mem[i]) spr_mem[i] = '0;
      foreach (nt_mem[i]) nt_mem[i] = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      expected_q.delete();
    end else begin
      // a result retires before a transfer on the same edge is predicted
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result strobe with no expectation pending");
          fail_total++;
        end else begin
          want = expected_q.pop_front();
          fail_total += check_field("read_data", want.read_data, read_data_i);
          fail_total += check_field("control", want.control, control_i);
          fail_total += check_field("mask_bits", want.mask_bits, mask_bits_i);
          fail_total += check_field("scroll_x", want.scroll_x, scroll_x_i);
          fail_total += check_field("scroll_y", want.scroll_y, scroll_y_i);
          fail_total += check_field("vblank", {7'd0, want.vblank}, {7'd0, vblank_i});
        end
      end
      if (start_i && !busy_i) begin
        expected_q.insert(expected_q.size(), apply_access(op_i, reg_index_i, data_i));
      end
    end
    outstanding_o <= expected_q.size();
    error_count_o <= fail_total;
  end

endmodule

### dv/video_register_port_unit_tb.sv
// Testbench top for the video register port: clock, reset, stimulus, watchdog and verdict.
module video_register_port_unit_tb;
  import vrp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         NtDepth       = NT_DEPTH_DEF;
  // covers the clearing pass after reset with a wide margin
  localparam int         WatchdogLimit = 4 * NtDepth + 256;
  localparam int         TotalItems    = 600;
  // last stretch of the run goes with back-to-back transfers
  localparam int         SteadyItems   = 100;
  localparam logic [1:0] OpUnused      = 2'd3;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       start_i;
  logic       busy_o;
  logic [1:0] op_i;
  logic [2:0] reg_index_i;
  logic [7:0] data_i;
  logic       done_o;
  logic [7:0] read_data_o;
  logic [7:0] control_o;
  logic [7:0] mask_bits_o;
  logic [7:0] scroll_x_o;
  logic [7:0] scroll_y_o;
  logic       vblank_o;

  int outstanding;
  int error_count;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit gaps_on     = 1'b1;

  // 20 ns period
  always #10 clk_i = ~clk_i;

  video_register_port_unit #(
    .NameTableDepth(NtDepth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .op_i       (op_i),
    .reg_index_i(reg_index_i),
    .data_i     (data_i),
    .done_o     (done_o),
    .read_data_o(read_data_o),
    .control_o  (control_o),
    .mask_bits_o(mask_bits_o),
    .scroll_x_o (scroll_x_o),
    .scroll_y_o (scroll_y_o),
    .vblank_o   (vblank_o)
  );

  vrp_port_checker #(
    .NameTableDepth(NtDepth)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_i       (busy_o),
    .op_i         (op_i),
    .reg_index_i  (reg_index_i),
    .data_i       (data_i),
    .done_i       (done_o),
    .read_data_i  (read_data_o),
    .control_i    (control_o),
    .mask_bits_i  (mask_bits_o),
    .scroll_x_i   (scroll_x_o),
    .scroll_y_i   (scroll_y_o),
    .vblank_i     (vblank_o),
    .outstanding_o(outstanding),
    .error_count_o(error_count)
  );

  // Watchdog: any cycle without a command transfer or a result strobe counts
  // toward the limit. The clearing pass after reset is the longest legal quiet
  // stretch; a missing result also ends up here.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Drives one command and holds it until the transfer edge. start_i stays
  // high into the next command unless a gap is inserted, so it never gets two
  // assignments in one step.
  task automatic send_item(input logic [1:0] op, input logic [2:0] idx, input logic [7:0] din);
    start_i     <= 1'b1;
    op_i        <= op;
    reg_index_i <= idx;
    data_i      <= din;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    items_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int         kind;
    int         n;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] spr_base;
    logic [2:0] dead_regs [5];

    dead_regs = '{REG_CONTROL, REG_MASK, REG_SPR_ADR, REG_SCROLL, REG_VADDR};

    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    op_i        <= OP_READ;
    reg_index_i <= REG_CONTROL;
    data_i      <= 8'h00;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ---------------- directed part ----------------
    // status read straight after reset returns 0xA0 and clears vblank
    send_item(OP_READ, REG_STATUS, 8'h00);
    // vblank event with junk on the data lines sets it again
    send_item(OP_VBLANK, REG_VDATA, 8'hFF);
    send_item(OP_READ, REG_STATUS, 8'hFF);
    // all-ones control selects the increment-by-32 step
    send_item(OP_WRITE, REG_CONTROL, 8'hFF);
    send_item(OP_WRITE, REG_MASK, 8'hFF);
    // sprite address wraps from 0xFF to 0x00 on the data write
    send_item(OP_WRITE, REG_SPR_ADR, 8'hFF);
    send_item(OP_WRITE, REG_SPR_DAT, 8'hA5);
    send_item(OP_WRITE, REG_SPR_ADR, 8'hFF);
    send_item(OP_READ, REG_SPR_DAT, 8'h00);
    // scroll pair through the shared toggle: extremes on both halves
    send_item(OP_WRITE, REG_SCROLL, 8'hFF);
    send_item(OP_WRITE, REG_SCROLL, 8'h00);
    // high byte 0xFF masks to 0x3F: address 0x3FFF, last palette slot
    send_item(OP_WRITE, REG_VADDR, 8'hFF);
    send_item(OP_WRITE, REG_VADDR, 8'hFF);
    // palette keeps six bits; step of 32 wraps the 14-bit address
    send_item(OP_WRITE, REG_VDATA, 8'hFF);
    send_item(OP_WRITE, REG_CONTROL, 8'h00);
    send_item(OP_WRITE, REG_VADDR, 8'h3F);
    send_item(OP_WRITE, REG_VADDR, 8'hFF);
    // read back the palette byte, address wraps to zero by one
    send_item(OP_READ, REG_VDATA, 8'h00);
    send_item(OP_WRITE, REG_VDATA, 8'h5A);
    // write to the status register is dropped
    send_item(OP_WRITE, REG_STATUS, 8'h55);
    // unused op code leaves the state alone
    send_item(OpUnused, REG_VDATA, 8'hFF);
    // write-only registers read as zero
    foreach (dead_regs[i]) send_item(OP_READ, dead_regs[i], 8'hFF);

    // ---------------- random part ----------------
    while (items_sent < TotalItems) begin
      if ($urandom_range(0, 15) == 0) gaps_on = !gaps_on;
      if (items_sent >= TotalItems - SteadyItems) gaps_on = 1'b0;
      kind = $urandom_range(0, 11);
      n    = $urandom_range(1, 8);
      case (kind)
        0, 1, 2, 3: begin
          // video memory burst: set address, write n bytes, rewind, read n + 1 bytes back
          hi = rand_byte();
          if ($urandom_range(0, 2) == 0) hi = hi | {2'b00, PAL_PAGE};
          lo = rand_byte();
          if ($urandom_range(0, 2) == 0) send_item(OP_WRITE, REG_CONTROL, rand_byte());
          send_item(OP_READ, REG_STATUS, rand_byte());
          send_item(OP_WRITE, REG_VADDR, hi);
          send_item(OP_WRITE, REG_VADDR, lo);
          repeat (n) send_item(OP_WRITE, REG_VDATA, rand_byte());
          send_item(OP_READ, REG_STATUS, rand_byte());
          send_item(OP_WRITE, REG_VADDR, hi);
          send_item(OP_WRITE, REG_VADDR, lo);
          repeat (n + 1) send_item(OP_READ, REG_VDATA, rand_byte());
        end
        4, 5: begin
          // sprite table: fill n bytes with post-increment, then spot-read each
          spr_base = rand_byte();
          send_item(OP_WRITE, REG_SPR_ADR, spr_base);
          repeat (n) send_item(OP_WRITE, REG_SPR_DAT, rand_byte());
          for (int k = 0; k < n; k++) begin
            send_item(OP_WRITE, REG_SPR_ADR, spr_base + 8'(k));
            send_item(OP_READ, REG_SPR_DAT, rand_byte());
          end
        end
        6: begin
          // scroll pair with the toggle reset first
          send_item(OP_READ, REG_STATUS, rand_byte());
          send_item(OP_WRITE, REG_SCROLL, rand_byte());
          send_item(OP_WRITE, REG_SCROLL, rand_byte());
        end
        7: begin
          send_item(OP_WRITE, REG_CONTROL, rand_byte());
          send_item(OP_WRITE, REG_MASK, rand_byte());
        end
        8: begin
          // vblank, sometimes polled right away
          send_item(OP_VBLANK, 3'($urandom_range(0, 7)), rand_byte());
          if ($urandom_range(0, 1) == 0) send_item(OP_READ, REG_STATUS, rand_byte());
        end
        9: begin
          // broken pair: a lone toggle write flips the shared toggle
          send_item(OP_WRITE, $urandom_range(0, 1) ? REG_SCROLL : REG_VADDR, rand_byte());
        end
        default: begin
          // noise over the whole command space, unused op code included
          repeat (n) send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), rand_byte());
        end
      endcase
    end

    // ---------------- drain and verdict ----------------
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/vrp_pkg.sv
hdl/vrp_ram.sv
hdl/vrp_ctrl.sv
hdl/vrp_dpath.sv
hdl/video_register_port_unit.sv
dv/vrp_port_checker.sv
dv/video_register_port_unit_tb.sv
